[design/font_table_directory_checker_core_assert.svh]
// ----------------------------------------------------------------------------
// Font table directory checker - assertion macros
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FONT_TABLE_DIRECTORY_CHECKER_CORE_ASSERT_SVH
`define FONT_TABLE_DIRECTORY_CHECKER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define FTDC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define FTDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define FTDC_ASSERT_NOW(lbl, ante, cons, msg)
`define FTDC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[design/ftdc_pkg.sv]
// ----------------------------------------------------------------------------
// ftdc_pkg
// Types, constants and helpers shared by the table directory checker.
// ----------------------------------------------------------------------------
`default_nettype none

package ftdc_pkg;

  localparam int MAX_TABLES = 128;
  localparam int MIN_TABLES = 3;
  localparam int DIR_HEAD   = 12;
  localparam int ENTRY_SIZE = 16;

  // position counter covers the whole directory
  localparam int POS_W = $clog2(DIR_HEAD + ENTRY_SIZE * MAX_TABLES + 1);
  localparam int CNT_W = $clog2(MAX_TABLES + 1);
  localparam int SEL_W = $clog2($clog2(MAX_TABLES + 1));
  localparam int ENT_W = POS_W - 4;

  localparam logic [7:0] TAG_LO = 8'h20;
  localparam logic [7:0] TAG_HI = 8'h7E;

  localparam logic [31:0] TAG_HEAD = 32'h68656164;
  localparam logic [31:0] TAG_CMAP = 32'h636D6170;
  localparam logic [31:0] TAG_GLYF = 32'h676C7966;
  localparam logic [31:0] TAG_CFF  = 32'h43464620;

  localparam logic [3:0] V_ACCEPT    = 4'd0;
  localparam logic [3:0] V_BAD_COUNT = 4'd1;
  localparam logic [3:0] V_BAD_SEL   = 4'd2;
  localparam logic [3:0] V_BAD_RANGE = 4'd3;
  localparam logic [3:0] V_BAD_TAG   = 4'd4;
  localparam logic [3:0] V_OVERLAP   = 4'd5;
  localparam logic [3:0] V_PAST_LIM  = 4'd6;
  localparam logic [3:0] V_NO_REQ    = 4'd7;
  localparam logic [3:0] V_TRUNC     = 4'd8;

  // header field offsets
  localparam logic [POS_W-1:0] P_COUNT_LO = POS_W'(5);
  localparam logic [POS_W-1:0] P_RANGE_LO = POS_W'(7);
  localparam logic [POS_W-1:0] P_SEL_LO   = POS_W'(9);

  // offsets within one directory entry
  localparam logic [3:0] O_TAG_LAST = 4'd3;
  localparam logic [3:0] O_OFS_LAST = 4'd11;
  localparam logic [3:0] O_LEN_LAST = 4'd15;

  typedef struct packed {
    logic [7:0]  byte_value;
    logic        start_flag;
    logic        end_of_data;
    logic [32:0] space_available;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  verdict;
    logic [32:0] end_offset;
  } out_item_t;

  typedef struct packed {
    logic      vld;
    out_item_t item;
  } result_t;

  // floor(log2(n)), capped at 15, zero for n < 2
  function automatic logic [3:0] floor_log2(input logic [15:0] n);
    logic [3:0] s;
    s = 4'd0;
    for (int i = 1; i < 16; i++) begin
      if ((n >> i) != 16'd0) s = 4'(i);
    end
    return s;
  endfunction

endpackage

`default_nettype wire

[design/ftdc_in_reg.sv]
// ----------------------------------------------------------------------------
// ftdc_in_reg
// Input register: captures one byte transfer per cycle while not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module ftdc_in_reg
  import ftdc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  input  wire logic     adv,
  output logic          item_vld,
  output in_item_t      item
);

  logic     vld_r;
  logic     vld_nxt;
  in_item_t data_r;

  // holds only while the checker cannot advance
  assign in_stall = vld_r && !adv;
  assign vld_nxt  = in_stall ? vld_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      data_r <= in_data;
    end
  end

  assign item_vld = vld_r;
  assign item     = data_r;

endmodule

`default_nettype wire

[design/ftdc_dir_check.sv]
// ----------------------------------------------------------------------------
// ftdc_dir_check
// Candidate state and per-byte directory checks; one byte per cycle while go.
// ----------------------------------------------------------------------------
`default_nettype none

module ftdc_dir_check
  import ftdc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     go,
  input  wire in_item_t item,
  output result_t       res
);

  logic [POS_W-1:0] pos_r,    pos_nxt;
  logic [CNT_W-1:0] cnt_r,    cnt_nxt;
  logic [15:0]      srange_r, srange_nxt;
  logic [SEL_W-1:0] sel_r,    sel_nxt;
  logic [31:0]      shift_r,  shift_nxt;
  logic [31:0]      tstart_r, tstart_nxt;
  logic [32:0]      fend_r,   fend_nxt;
  logic             req_r,    req_nxt;
  logic [32:0]      limit_r,  limit_nxt;
  logic             act_r,    act_nxt;

  logic             start;
  logic             act_cur;
  logic [POS_W-1:0] pos_cur;
  logic [CNT_W-1:0] cnt_cur;
  logic [15:0]      srange_cur;
  logic [SEL_W-1:0] sel_cur;
  logic [31:0]      shift_cur;
  logic [31:0]      tstart_cur;
  logic [32:0]      fend_cur;
  logic             req_cur;
  logic [32:0]      limit_cur;

  logic [POS_W-1:0] rel;
  logic [3:0]       ofs;
  logic [ENT_W-1:0] entry;
  logic [15:0]      half;
  logic [3:0]       lg;
  logic [32:0]      dir_end;
  logic [32:0]      tend;
  logic [32:0]      fend_upd;
  logic             last_entry;
  logic             done;
  logic [3:0]       code;

  // a start byte sees the reset state, with limit from space_available
  assign start      = item.start_flag;
  assign act_cur    = start || act_r;
  assign pos_cur    = start ? '0 : pos_r;
  assign cnt_cur    = start ? '0 : cnt_r;
  assign srange_cur = start ? '0 : srange_r;
  assign sel_cur    = start ? '0 : sel_r;
  assign shift_cur  = start ? '0 : shift_r;
  assign tstart_cur = start ? '0 : tstart_r;
  assign fend_cur   = start ? '0 : fend_r;
  assign req_cur    = start ? 1'b0 : req_r;
  assign limit_cur  = start ? item.space_available : limit_r;

  assign rel        = pos_cur - POS_W'(DIR_HEAD);
  assign ofs        = rel[3:0];
  assign entry      = rel[POS_W-1:4];
  assign half       = shift_nxt[15:0];
  assign lg         = floor_log2(half);
  assign dir_end    = 33'(DIR_HEAD) + (33'(cnt_cur) << 4);
  assign tend       = 33'(tstart_cur) + 33'(shift_nxt);
  assign fend_upd   = (tend > fend_cur) ? tend : fend_cur;
  assign last_entry = ((POS_W + 1)'(entry) + (POS_W + 1)'(1)) >= (POS_W + 1)'(cnt_cur);

  always_comb begin
    pos_nxt    = pos_r;
    cnt_nxt    = cnt_r;
    srange_nxt = srange_r;
    sel_nxt    = sel_r;
    shift_nxt  = {shift_cur[23:0], item.byte_value};
    tstart_nxt = tstart_r;
    fend_nxt   = fend_r;
    req_nxt    = req_r;
    limit_nxt  = limit_r;
    act_nxt    = act_r;
    done       = 1'b0;
    code       = V_ACCEPT;

    if (go && act_cur) begin
      pos_nxt    = pos_cur + POS_W'(1);
      cnt_nxt    = cnt_cur;
      srange_nxt = srange_cur;
      sel_nxt    = sel_cur;
      tstart_nxt = tstart_cur;
      fend_nxt   = fend_cur;
      req_nxt    = req_cur;
      limit_nxt  = limit_cur;
      act_nxt    = 1'b1;

      if (pos_cur == P_COUNT_LO) begin
        if (half < 16'(MIN_TABLES) || half > 16'(MAX_TABLES)) begin
          done = 1'b1;
          code = V_BAD_COUNT;
        end else begin
          cnt_nxt  = half[CNT_W-1:0];
          sel_nxt  = lg[SEL_W-1:0];
          fend_nxt = 33'(DIR_HEAD) + (33'(half) << 4);
        end
      end else if (pos_cur == P_RANGE_LO) begin
        srange_nxt = half;
      end else if (pos_cur == P_SEL_LO) begin
        if (half != 16'(sel_cur)) begin
          done = 1'b1;
          code = V_BAD_SEL;
        end else if (srange_cur != (16'(ENTRY_SIZE) << sel_cur)) begin
          done = 1'b1;
          code = V_BAD_RANGE;
        end
      end else if (pos_cur >= POS_W'(DIR_HEAD)) begin
        if (ofs <= O_TAG_LAST) begin
          if (item.byte_value < TAG_LO || item.byte_value > TAG_HI) begin
            done = 1'b1;
            code = V_BAD_TAG;
          end else if (ofs == O_TAG_LAST) begin
            if (shift_nxt == TAG_HEAD || shift_nxt == TAG_CMAP ||
                shift_nxt == TAG_GLYF || shift_nxt == TAG_CFF) begin
              req_nxt = 1'b1;
            end
          end
        end else if (ofs == O_OFS_LAST) begin
          tstart_nxt = shift_nxt;
          if ({1'b0, shift_nxt} < dir_end) begin
            done = 1'b1;
            code = V_OVERLAP;
          end
        end else if (ofs == O_LEN_LAST) begin
          if (tend > limit_cur) begin
            done = 1'b1;
            code = V_PAST_LIM;
          end else begin
            fend_nxt = fend_upd;
            if (last_entry) begin
              done = 1'b1;
              code = req_cur ? V_ACCEPT : V_NO_REQ;
            end
          end
        end
      end

      if (!done && item.end_of_data) begin
        done = 1'b1;
        code = V_TRUNC;
      end
      if (done) act_nxt = 1'b0;
    end else begin
      shift_nxt = shift_r;
    end
  end

  assign res.vld             = done;
  assign res.item.verdict    = code;
  assign res.item.end_offset = (code == V_ACCEPT) ? fend_upd : 33'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      cnt_r    <= '0;
      srange_r <= '0;
      sel_r    <= '0;
      shift_r  <= '0;
      tstart_r <= '0;
      fend_r   <= '0;
      req_r    <= 1'b0;
      limit_r  <= '0;
      act_r    <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      cnt_r    <= cnt_nxt;
      srange_r <= srange_nxt;
      sel_r    <= sel_nxt;
      shift_r  <= shift_nxt;
      tstart_r <= tstart_nxt;
      fend_r   <= fend_nxt;
      req_r    <= req_nxt;
      limit_r  <= limit_nxt;
      act_r    <= act_nxt;
    end
  end

endmodule

`default_nettype wire

[design/ftdc_out_reg.sv]
// ----------------------------------------------------------------------------
// ftdc_out_reg
// Verdict output register; holds its transfer while the receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module ftdc_out_reg
  import ftdc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire result_t res,
  output logic         adv,
  output logic         out_valid,
  input  wire logic    out_stall,
  output out_item_t    out_data
);

  logic      vld_r;
  logic      vld_nxt;
  out_item_t data_r;

  assign adv     = !vld_r || !out_stall;
  assign vld_nxt = adv ? res.vld : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.vld) begin
      data_r <= res.item;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

[design/font_table_directory_checker_core.sv]
// ----------------------------------------------------------------------------
// font_table_directory_checker_core
// Streams candidate font bytes and validates the sfnt table directory.
//
// Input channel (in_valid / in_stall / in_data): one byte per transfer, with
// start_flag on offset 0 of a candidate (space_available sampled there) and
// end_of_data on the last byte the source can give. Bytes outside a candidate
// are dropped. A start in mid-candidate abandons the old one silently.
// Result channel (out_valid / out_stall / out_data): one verdict per decided
// candidate, with the furthest table end on acceptance and zero otherwise.
// The deciding byte sits in the input register after its transfer; the verdict
// register loads from it once the checker can advance, and out_valid rises
// with that load. Throughput: one byte per cycle while the output is not
// stalled; all checks for a byte sit between those two registers.
// A stalled verdict holds in the output register and the checker pauses: one
// more byte may be taken into the input register, then in_stall stays high
// until the verdict transfers.
// Reset (synchronous, rst_n low) empties both registers and leaves the
// checker idle, waiting for a start byte.
// ----------------------------------------------------------------------------
`default_nettype none

module font_table_directory_checker_core
  import ftdc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_data
);

`include "font_table_directory_checker_core_assert.svh"

  logic     adv;
  logic     item_vld;
  in_item_t item;
  result_t  res;

  ftdc_in_reg u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .adv      (adv),
    .item_vld (item_vld),
    .item     (item)
  );

  ftdc_dir_check u_chk (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (item_vld && adv),
    .item  (item),
    .res   (res)
  );

  ftdc_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .adv       (adv),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `FTDC_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without output backpressure")
  `FTDC_ASSERT_NOW(a_reject_zero, out_valid && out_data.verdict != V_ACCEPT, out_data.end_offset == 33'd0, "reject carries nonzero end offset")
  `FTDC_ASSERT_NOW(a_accept_min, out_valid && out_data.verdict == V_ACCEPT, out_data.end_offset >= 33'(DIR_HEAD + ENTRY_SIZE * MIN_TABLES), "accepted end offset below directory end")
  `FTDC_ASSERT_NEXT(a_res_lands, res.vld && adv, out_valid, "decided verdict not registered")

endmodule

`default_nettype wire
